FILE: sv/whitened_digest_sensor_frame_decoder_unit_assert.svh
// Assertion macros of the frame decoder, included by the capture module.
`ifndef WHITENED_DIGEST_SENSOR_FRAME_DECODER_UNIT_ASSERT_SVH
`define WHITENED_DIGEST_SENSOR_FRAME_DECODER_UNIT_ASSERT_SVH
`ifndef SYNTH
`define WDSFD_ASSERT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("frame decoder check failed");
`define WDSFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("frame decoder check failed");
`else
`define WDSFD_ASSERT(label, ante, cons)
`define WDSFD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: sv/wdsfd_pkg.sv
// Types, constants and helper functions of the whitened digest frame decoder.
package wdsfd_pkg;

    localparam int FRAME_LEN = 25;
    localparam int CNT_W     = $clog2(FRAME_LEN);

    localparam logic [15:0] GEN_POLY_RST   = 16'h8810;
    localparam logic [15:0] DIGEST_KEY_RST = 16'hBA95;
    localparam logic [15:0] FINAL_XOR_RST  = 16'h6DF1;
    localparam logic [7:0]  WHITEN_RST     = 8'hAA;

    localparam logic [7:0]  BATT_MASK      = 8'h06;
    localparam logic [11:0] TEMP_WRAP_LIM  = 12'd600;
    localparam logic [11:0] TEMP_WRAP_OFS  = 12'd1000;

    localparam logic [3:0]  TYPE_WEATHER   = 4'd1;
    localparam logic [3:0]  TYPE_RAIN      = 4'd12;
    localparam logic [3:0]  TYPE_COMBO     = 4'd13;

    typedef logic [7:0] byte_t;

    typedef enum logic [1:0] {
        REG_GEN_POLY   = 2'd0,
        REG_DIGEST_KEY = 2'd1,
        REG_FINAL_XOR  = 2'd2,
        REG_WHITEN     = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_SHORT  = 3'd1,
        ST_EMPTY  = 3'd2,
        ST_DIGEST = 3'd3,
        ST_TYPE   = 3'd4
    } status_t;

    typedef struct packed {
        logic [15:0] gen_poly;
        logic [15:0] digest_key;
        logic [15:0] final_xor;
        byte_t       whiten;
    } cfg_t;

    typedef struct packed {
        logic [15:0] sum;
        logic [15:0] key;
    } digest_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [15:0]      digest;
    } frame_info_t;

    typedef struct packed {
        status_t            status;
        logic [15:0]        sensor_id;
        logic [3:0]         dev_type;
        logic               battery_ok;
        logic signed [10:0] temperature_tenths;
        logic [7:0]         humidity;
        logic [20:0]        rain_tenths;
        logic [10:0]        wind_dir_deg;
        logic [10:0]        gust_tenths;
        logic [10:0]        wind_avg_tenths;
        logic [20:0]        light_lux;
        logic [10:0]        uv_tenths;
    } record_t;

    // Eight LFSR shifts, most significant data bit first.
    function automatic digest_t digest_byte(digest_t cur, logic [15:0] poly, byte_t d);
        digest_t st;
        st = cur;
        for (int i = 7; i >= 0; i--) begin
            if (d[i]) begin
                st.sum = st.sum ^ st.key;
            end
            if (st.key[0]) begin
                st.key = (st.key >> 1) ^ poly;
            end else begin
                st.key = st.key >> 1;
            end
        end
        return st;
    endfunction

    function automatic logic [10:0] bcd3(logic [3:0] d2, logic [3:0] d1, logic [3:0] d0);
        return 11'(d2) * 11'd100 + 11'(d1) * 11'd10 + 11'(d0);
    endfunction

    function automatic logic [20:0] bcd6(byte_t b2, byte_t b1, byte_t b0);
        return 21'(b2[7:4]) * 21'd100000 + 21'(b2[3:0]) * 21'd10000
             + 21'(b1[7:4]) * 21'd1000 + 21'(b1[3:0]) * 21'd100
             + 21'(b0[7:4]) * 21'd10 + 21'(b0[3:0]);
    endfunction

endpackage

FILE: sv/wdsfd_capture.sv
// Byte counter, running digest and raw frame store, with a snapshot taken at each frame end.
module wdsfd_capture (
    input  logic                                     aclk,
    input  logic                                     aresetn,
    input  logic                                     accept,
    input  wdsfd_pkg::byte_t                         data_byte,
    input  logic                                     frame_end,
    input  wdsfd_pkg::cfg_t                          cfg,
    input  logic                                     release_i,
    output logic                                     pend_valid,
    output wdsfd_pkg::frame_info_t                   info,
    output wdsfd_pkg::byte_t                         store [wdsfd_pkg::FRAME_LEN]
);

`include "whitened_digest_sensor_frame_decoder_unit_assert.svh"

    localparam logic [wdsfd_pkg::CNT_W-1:0] LEN_C = wdsfd_pkg::CNT_W'(wdsfd_pkg::FRAME_LEN);
    localparam logic [wdsfd_pkg::CNT_W-1:0] FIRST_DIGEST_C = wdsfd_pkg::CNT_W'(2);

    logic [wdsfd_pkg::CNT_W-1:0] cnt_reg;
    logic [wdsfd_pkg::CNT_W-1:0] cnt_next;
    logic                        pend_reg;
    wdsfd_pkg::digest_t          dig_reg;
    wdsfd_pkg::digest_t          dig_base;
    wdsfd_pkg::digest_t          dig_step;
    wdsfd_pkg::digest_t          dig_next;
    wdsfd_pkg::frame_info_t      info_reg;
    wdsfd_pkg::byte_t            store_reg [wdsfd_pkg::FRAME_LEN];
    logic                        in_range;

    assign in_range = cnt_reg < LEN_C;

    always_comb begin
        if (cnt_reg == '0) begin
            dig_base.sum = '0;
            dig_base.key = cfg.digest_key;
        end else begin
            dig_base = dig_reg;
        end
        dig_step = wdsfd_pkg::digest_byte(dig_base, cfg.gen_poly, data_byte ^ cfg.whiten);
        dig_next = (in_range && cnt_reg >= FIRST_DIGEST_C) ? dig_step : dig_base;
        cnt_next = in_range ? cnt_reg + 1'b1 : cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            pend_reg <= 1'b0;
        end else begin
            if (release_i) begin
                pend_reg <= 1'b0;
            end
            if (accept) begin
                if (frame_end) begin
                    cnt_reg  <= '0;
                    pend_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_next;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            dig_reg <= dig_next;
            if (frame_end) begin
                info_reg.count  <= cnt_next;
                info_reg.digest <= dig_next.sum;
            end
            if (in_range) begin
                store_reg[cnt_reg] <= data_byte;
            end
        end
    end

    assign pend_valid = pend_reg;
    assign info       = info_reg;
    assign store      = store_reg;

    `WDSFD_ASSERT(a_cnt_range, 1'b1, cnt_reg <= LEN_C)
    `WDSFD_ASSERT_NEXT(a_end_pends, accept && frame_end, pend_reg && cnt_reg == '0)
    `WDSFD_ASSERT_NEXT(a_pend_holds, pend_reg && !release_i, pend_reg && $stable(info_reg))

endmodule

FILE: sv/wdsfd_decode.sv
// Frame checks and field decoding from the stored frame and its snapshot.
module wdsfd_decode (
    input  wdsfd_pkg::byte_t       store [wdsfd_pkg::FRAME_LEN],
    input  wdsfd_pkg::frame_info_t info,
    input  wdsfd_pkg::cfg_t        cfg,
    output wdsfd_pkg::record_t     rec
);

    wdsfd_pkg::byte_t    m [wdsfd_pkg::FRAME_LEN];
    logic [3:0]          ftype;
    logic [15:0]         chk;
    logic [11:0]         temp_bcd;
    wdsfd_pkg::status_t  status;

    always_comb begin
        for (int i = 0; i < wdsfd_pkg::FRAME_LEN; i++) begin
            m[i] = store[i] ^ cfg.whiten;
        end
        ftype    = m[6][7:4];
        chk      = {m[0], m[1]};
        temp_bcd = {1'b0, wdsfd_pkg::bcd3(m[14][7:4], m[14][3:0], m[15][7:4])};

        if (info.count < wdsfd_pkg::CNT_W'(wdsfd_pkg::FRAME_LEN)) begin
            status = wdsfd_pkg::ST_SHORT;
        end else if (store[21] == '0) begin
            status = wdsfd_pkg::ST_EMPTY;
        end else if ((chk ^ info.digest) != cfg.final_xor) begin
            status = wdsfd_pkg::ST_DIGEST;
        end else if (ftype != wdsfd_pkg::TYPE_WEATHER && ftype != wdsfd_pkg::TYPE_RAIN
                     && ftype != wdsfd_pkg::TYPE_COMBO) begin
            status = wdsfd_pkg::ST_TYPE;
        end else begin
            status = wdsfd_pkg::ST_OK;
        end

        rec        = '0;
        rec.status = status;
        if (status == wdsfd_pkg::ST_OK) begin
            rec.sensor_id   = {m[2], m[3]};
            rec.dev_type    = ftype;
            rec.battery_ok  = ((m[15] & wdsfd_pkg::BATT_MASK) != wdsfd_pkg::BATT_MASK);
            if (temp_bcd > wdsfd_pkg::TEMP_WRAP_LIM) begin
                rec.temperature_tenths = 11'(temp_bcd - wdsfd_pkg::TEMP_WRAP_OFS);
            end else begin
                rec.temperature_tenths = 11'(temp_bcd);
            end
            rec.humidity    = 8'({4'b0, m[16][7:4]} * 8'd10 + {4'b0, m[16][3:0]});
            rec.rain_tenths = wdsfd_pkg::bcd6(m[10], m[11], m[12]);
            if (ftype != wdsfd_pkg::TYPE_RAIN) begin
                rec.wind_dir_deg    = wdsfd_pkg::bcd3(m[4][7:4], m[4][3:0], m[5][7:4]);
                rec.gust_tenths     = wdsfd_pkg::bcd3(m[7][7:4], m[7][3:0], m[8][7:4]);
                rec.wind_avg_tenths = wdsfd_pkg::bcd3(m[8][3:0], m[9][7:4], m[9][3:0]);
                rec.light_lux       = wdsfd_pkg::bcd6(m[17], m[18], m[19]);
                rec.uv_tenths       = wdsfd_pkg::bcd3(m[20][7:4], m[20][3:0], m[21][7:4]);
            end
        end
    end

endmodule

FILE: sv/whitened_digest_sensor_frame_decoder_unit.sv
// Top level of the whitened digest sensor frame decoder.
//
// The slave channel carries one raw frame byte per transaction in s_tdata, with
// s_tlast set on the last byte of a frame. The master channel delivers one
// decoded record for each frame: the status in m_tuser and the fields in m_tdata.
// Every byte is whitened, and bytes 2 to 24 pass through the digest LFSR in the
// cycle in which they are accepted; later bytes are dropped.
// One byte is taken per cycle while s_tready is high. Accepting the last byte
// of a frame fills the frame snapshot; once the output register is free, the
// result of the check and decode logic is registered there and m_tvalid rises.
// The configuration registers are written through cfg_wr_en, cfg_index and
// cfg_wdata, and should only change while no frame is in progress.
// Synchronous reset clears the byte count and the record flags and reloads the
// configuration defaults. When the receiver stalls, the finished record waits in
// the output register; one more frame end may be held in the snapshot, after
// which s_tready drops until the output register frees.
module whitened_digest_sensor_frame_decoder_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] data_byte
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // [15:0] sensor_id, [19:16] dev_type, [20] battery_ok,
    // [31:21] temperature_tenths, [39:32] humidity, [60:40] rain_tenths,
    // [71:61] wind_dir_deg, [82:72] gust_tenths, [93:83] wind_avg_tenths,
    // [114:94] light_lux, [125:115] uv_tenths, [127:126] zero
    output logic [127:0] m_tdata,
    output logic [2:0]   m_tuser,   // [2:0] status
    input  logic         cfg_wr_en,
    input  logic [1:0]   cfg_index,
    input  logic [15:0]  cfg_wdata
);

    wdsfd_pkg::cfg_t        cfg_reg;
    wdsfd_pkg::frame_info_t info;
    wdsfd_pkg::byte_t       store [wdsfd_pkg::FRAME_LEN];
    wdsfd_pkg::record_t     rec_next;
    wdsfd_pkg::record_t     rec_reg;
    logic                   out_valid_reg;
    logic                   pend_valid;
    logic                   move;
    logic                   accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gen_poly   <= wdsfd_pkg::GEN_POLY_RST;
            cfg_reg.digest_key <= wdsfd_pkg::DIGEST_KEY_RST;
            cfg_reg.final_xor  <= wdsfd_pkg::FINAL_XOR_RST;
            cfg_reg.whiten     <= wdsfd_pkg::WHITEN_RST;
        end else if (cfg_wr_en) begin
            unique case (wdsfd_pkg::cfg_reg_t'(cfg_index))
                wdsfd_pkg::REG_GEN_POLY:   cfg_reg.gen_poly   <= cfg_wdata;
                wdsfd_pkg::REG_DIGEST_KEY: cfg_reg.digest_key <= cfg_wdata;
                wdsfd_pkg::REG_FINAL_XOR:  cfg_reg.final_xor  <= cfg_wdata;
                wdsfd_pkg::REG_WHITEN:     cfg_reg.whiten     <= cfg_wdata[7:0];
            endcase
        end
    end

    assign move     = pend_valid && (!out_valid_reg || m_tready);
    assign s_tready = !pend_valid || move;
    assign accept   = s_tvalid && s_tready;

    wdsfd_capture u_capture (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .accept     (accept),
        .data_byte  (s_tdata),
        .frame_end  (s_tlast),
        .cfg        (cfg_reg),
        .release_i  (move),
        .pend_valid (pend_valid),
        .info       (info),
        .store      (store)
    );

    wdsfd_decode u_decode (
        .store (store),
        .info  (info),
        .cfg   (cfg_reg),
        .rec   (rec_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (move) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (move) begin
            rec_reg <= rec_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = rec_reg.status;
    assign m_tdata  = {2'b00, rec_reg.uv_tenths, rec_reg.light_lux, rec_reg.wind_avg_tenths,
                       rec_reg.gust_tenths, rec_reg.wind_dir_deg, rec_reg.rain_tenths,
                       rec_reg.humidity, rec_reg.temperature_tenths, rec_reg.battery_ok,
                       rec_reg.dev_type, rec_reg.sensor_id};

endmodule

FILE: sim/whitened_digest_sensor_frame_decoder_unit_tb.sv
// Self-checking testbench of the whitened digest sensor frame decoder unit.
class frame_record_predictor;
    logic [15:0]          poly;
    logic [15:0]          key_init;
    logic [15:0]          final_xor;
    wdsfd_pkg::byte_t     whiten;
    logic [4:0]           count;
    logic [15:0]          sum;
    logic [15:0]          key;
    wdsfd_pkg::byte_t     store [wdsfd_pkg::FRAME_LEN];
    wdsfd_pkg::record_t   expected_records [$];
    int                   errors;

    function new();
        poly      = wdsfd_pkg::GEN_POLY_RST;
        key_init  = wdsfd_pkg::DIGEST_KEY_RST;
        final_xor = wdsfd_pkg::FINAL_XOR_RST;
        whiten    = wdsfd_pkg::WHITEN_RST;
        count     = '0;
        sum       = '0;
        key       = key_init;
        errors    = 0;
        foreach (store[i]) store[i] = '0;
    endfunction

    function void set_reg(wdsfd_pkg::cfg_reg_t idx, logic [15:0] v);
        case (idx)
            wdsfd_pkg::REG_GEN_POLY:   poly = v;
            wdsfd_pkg::REG_DIGEST_KEY: key_init = v;
            wdsfd_pkg::REG_FINAL_XOR:  final_xor = v;
            wdsfd_pkg::REG_WHITEN:     whiten = v[7:0];
            default: ;
        endcase
    endfunction

    function void mix_byte(inout logic [15:0] s, inout logic [15:0] k,
                           input wdsfd_pkg::byte_t d);
        for (int i = 7; i >= 0; i--) begin
            if (d[i]) s = s ^ k;
            k = k[0] ? ((k >> 1) ^ poly) : (k >> 1);
        end
    endfunction

    function logic [15:0] frame_digest(wdsfd_pkg::byte_t m [wdsfd_pkg::FRAME_LEN]);
        logic [15:0] s;
        logic [15:0] k;
        s = '0;
        k = key_init;
        for (int i = 2; i < wdsfd_pkg::FRAME_LEN; i++) mix_byte(s, k, m[i]);
        return s;
    endfunction

    function int dec3(int a, int b, int c);
        return a * 100 + b * 10 + c;
    endfunction

    function int dec6(wdsfd_pkg::byte_t x, wdsfd_pkg::byte_t y, wdsfd_pkg::byte_t z);
        return dec3(x[7:4], x[3:0], y[7:4]) * 1000 + dec3(y[3:0], z[7:4], z[3:0]);
    endfunction

    function wdsfd_pkg::record_t decode_frame();
        wdsfd_pkg::byte_t   m [wdsfd_pkg::FRAME_LEN];
        wdsfd_pkg::record_t r;
        logic [3:0]         ty;
        logic [15:0]        chk;
        int                 t;
        r = '0;
        foreach (m[i]) m[i] = store[i] ^ whiten;
        ty  = m[6][7:4];
        chk = {m[0], m[1]};
        if (count < wdsfd_pkg::FRAME_LEN) r.status = wdsfd_pkg::ST_SHORT;
        else if (store[21] == 8'h00) r.status = wdsfd_pkg::ST_EMPTY;
        else if ((chk ^ sum) != final_xor) r.status = wdsfd_pkg::ST_DIGEST;
        else if (ty != wdsfd_pkg::TYPE_WEATHER && ty != wdsfd_pkg::TYPE_RAIN
                 && ty != wdsfd_pkg::TYPE_COMBO) r.status = wdsfd_pkg::ST_TYPE;
        else r.status = wdsfd_pkg::ST_OK;
        if (r.status != wdsfd_pkg::ST_OK) return r;
        r.sensor_id   = {m[2], m[3]};
        r.dev_type    = ty;
        r.battery_ok  = ((m[15] & wdsfd_pkg::BATT_MASK) != wdsfd_pkg::BATT_MASK);
        t = dec3(m[14][7:4], m[14][3:0], m[15][7:4]);
        if (t > 600) t = t - 1000;
        r.temperature_tenths = 11'(t);
        r.humidity    = 8'(m[16][7:4] * 10 + m[16][3:0]);
        r.rain_tenths = 21'(dec6(m[10], m[11], m[12]));
        if (ty != wdsfd_pkg::TYPE_RAIN) begin
            r.wind_dir_deg    = 11'(dec3(m[4][7:4], m[4][3:0], m[5][7:4]));
            r.gust_tenths     = 11'(dec3(m[7][7:4], m[7][3:0], m[8][7:4]));
            r.wind_avg_tenths = 11'(dec3(m[8][3:0], m[9][7:4], m[9][3:0]));
            r.light_lux       = 21'(dec6(m[17], m[18], m[19]));
            r.uv_tenths       = 11'(dec3(m[20][7:4], m[20][3:0], m[21][7:4]));
        end
        return r;
    endfunction

    function void note_byte(wdsfd_pkg::byte_t b, logic last);
        if (count == 0) begin
            key = key_init;
            sum = '0;
        end
        if (count < wdsfd_pkg::FRAME_LEN) begin
            store[count] = b;
            if (count >= 2) mix_byte(sum, key, b ^ whiten);
            count++;
        end
        if (last) begin
            expected_records.push_back(decode_frame());
            count = '0;
            sum   = '0;
            key   = key_init;
        end
    endfunction

    function void check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endfunction

    function void check_record(logic [127:0] d, logic [2:0] u);
        wdsfd_pkg::record_t e;
        if (expected_records.size() == 0) begin
            $error("record with status %0d arrived with none outstanding", u);
            errors++;
            return;
        end
        e = expected_records.pop_front();
        check_field("status", e.status, u);
        check_field("sensor_id", e.sensor_id, d[15:0]);
        check_field("dev_type", e.dev_type, d[19:16]);
        check_field("battery_ok", e.battery_ok, d[20]);
        check_field("temperature_tenths", $signed(e.temperature_tenths), $signed(d[31:21]));
        check_field("humidity", e.humidity, d[39:32]);
        check_field("rain_tenths", e.rain_tenths, d[60:40]);
        check_field("wind_dir_deg", e.wind_dir_deg, d[71:61]);
        check_field("gust_tenths", e.gust_tenths, d[82:72]);
        check_field("wind_avg_tenths", e.wind_avg_tenths, d[93:83]);
        check_field("light_lux", e.light_lux, d[114:94]);
        check_field("uv_tenths", e.uv_tenths, d[125:115]);
        check_field("padding", 0, d[127:126]);
    endfunction

    function int pending();
        return expected_records.size();
    endfunction
endclass

module whitened_digest_sensor_frame_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 4000;

    typedef enum int {
        FR_GOOD,
        FR_BAD_DIGEST,
        FR_EMPTY,
        FR_BAD_TYPE,
        FR_SHORT,
        FR_NOISE,
        FR_EXTREME
    } frame_kind_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [7:0]   s_tdata = '0;
    logic         s_tlast = 1'b0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [127:0] m_tdata;
    logic [2:0]   m_tuser;
    logic         cfg_wr_en = 1'b0;
    logic [1:0]   cfg_index = '0;
    logic [15:0]  cfg_wdata = '0;

    frame_record_predictor sb = new();
    wdsfd_pkg::byte_t frame_bytes [$];
    int    calm = 0;
    int    idle_cycles = 0;

    whitened_digest_sensor_frame_decoder_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_record(m_tdata, m_tuser);
            if (s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= IDLE_LIMIT) begin
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    initial begin
        int stall;
        wait (aresetn);
        @(posedge aclk);
        forever begin
            stall = calm ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    task automatic send_byte(wdsfd_pkg::byte_t b, logic last);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_reg(wdsfd_pkg::cfg_reg_t idx, logic [15:0] v);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= v;
        @(posedge aclk);
        sb.set_reg(idx, v);
    endtask

    // The frame is built unwhitened; the check word is then fitted to the
    // digest so that well-formed frames pass, and corrupted on request.
    task automatic build_frame(frame_kind_t kind);
        wdsfd_pkg::byte_t m [wdsfd_pkg::FRAME_LEN];
        logic [15:0]      chk;
        logic [3:0]       ty;
        logic             bcd;
        int               len;
        frame_bytes.delete();
        bcd = ($urandom_range(0, 3) != 0);
        foreach (m[i]) begin
            if (bcd) m[i] = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
            else m[i] = 8'($urandom);
        end
        if (kind == FR_EXTREME) begin
            foreach (m[i]) m[i] = 8'h99;
            m[15] = 8'h96;
            ty = wdsfd_pkg::TYPE_COMBO;
        end else if (kind == FR_BAD_TYPE) begin
            do ty = 4'($urandom);
            while (ty == wdsfd_pkg::TYPE_WEATHER || ty == wdsfd_pkg::TYPE_RAIN
                   || ty == wdsfd_pkg::TYPE_COMBO);
        end else begin
            case ($urandom_range(0, 2))
                0: ty = wdsfd_pkg::TYPE_WEATHER;
                1: ty = wdsfd_pkg::TYPE_RAIN;
                default: ty = wdsfd_pkg::TYPE_COMBO;
            endcase
        end
        m[6][7:4] = ty;
        if (kind == FR_EMPTY) m[21] = sb.whiten;
        else while (m[21] == sb.whiten) m[21] = 8'($urandom);
        chk = sb.frame_digest(m) ^ sb.final_xor;
        if (kind == FR_BAD_DIGEST) chk = chk ^ (16'd1 << $urandom_range(0, 15));
        m[0] = chk[15:8];
        m[1] = chk[7:0];
        case (kind)
            FR_SHORT:   len = $urandom_range(1, wdsfd_pkg::FRAME_LEN - 1);
            FR_NOISE:   len = $urandom_range(1, 32);
            FR_EXTREME: len = wdsfd_pkg::FRAME_LEN;
            default:    len = ($urandom_range(0, 4) == 0) ? $urandom_range(26, 33)
                                                          : wdsfd_pkg::FRAME_LEN;
        endcase
        for (int i = 0; i < len; i++) begin
            if (kind == FR_NOISE || i >= wdsfd_pkg::FRAME_LEN) begin
                frame_bytes.push_back(8'($urandom));
            end else begin
                frame_bytes.push_back(m[i] ^ sb.whiten);
            end
        end
    endtask

    initial begin
        frame_kind_t         kind;
        wdsfd_pkg::cfg_reg_t idx;
        logic [15:0]         v;
        int                  phase_items;
        int                  w;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        build_frame(FR_EXTREME);
        send_frame();
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);

        for (int p = 0; p < 6; p++) begin
            if (p > 0) begin
                wait_drained();
                for (int r = 0; r < 4; r++) begin
                    idx = wdsfd_pkg::cfg_reg_t'(r);
                    case (p)
                        1: v = 16'h0000;
                        2: v = 16'hFFFF;
                        5: case (idx)
                            wdsfd_pkg::REG_GEN_POLY:   v = wdsfd_pkg::GEN_POLY_RST;
                            wdsfd_pkg::REG_DIGEST_KEY: v = wdsfd_pkg::DIGEST_KEY_RST;
                            wdsfd_pkg::REG_FINAL_XOR:  v = wdsfd_pkg::FINAL_XOR_RST;
                            default:                   v = 16'(wdsfd_pkg::WHITEN_RST);
                        endcase
                        default: v = 16'($urandom);
                    endcase
                    write_reg(idx, v);
                end
                cfg_wr_en <= 1'b0;
            end
            calm = (p == 3) || ($urandom_range(0, 3) == 0);
            phase_items = 0;
            while (phase_items < 145) begin
                w = $urandom_range(0, 99);
                if (w < 55) kind = FR_GOOD;
                else if (w < 65) kind = FR_BAD_DIGEST;
                else if (w < 72) kind = FR_EMPTY;
                else if (w < 80) kind = FR_BAD_TYPE;
                else if (w < 90) kind = FR_SHORT;
                else kind = FR_NOISE;
                build_frame(kind);
                send_frame();
                phase_items += frame_bytes.size();
                if ($urandom_range(0, 11) == 0) wait_drained();
            end
        end

        s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
